FILE: rtl/csr_sparse_matrix_vector_multiply_assert.svh
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector multiply assertion macros
// Concurrent assertion wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`ifndef SYNTHESIS
`define CSMV_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define CSMV_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CSMV_ASSERT(name, prop, msg)
`define CSMV_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

FILE: rtl/csmv_pkg.sv
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector multiply package
// Sizes, request opcodes and derived widths shared by the block.
// ----------------------------------------------------------------------------
package csmv_pkg;

    localparam int VECTOR_DEPTH = 4096;
    localparam int MAX_ROWS     = 65536;

    localparam int ADDR_W  = $clog2(VECTOR_DEPTH);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int INDEX_W = 12;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 48;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int FRAC_W  = 16;

    typedef logic [1:0] t_op;

    localparam t_op OP_LOAD    = 2'd0;
    localparam t_op OP_NONZERO = 2'd1;
    localparam t_op OP_ROW_END = 2'd2;

endpackage

FILE: rtl/csr_sparse_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector multiply
// Accumulates matrix rows against a stored dense vector, one request a cycle unless stalled.
// ----------------------------------------------------------------------------
// The request channel (i_valid, o_ready) carries op, index and value. A load
// writes one vector element, a nonzero multiplies its value by the stored
// element at its column and adds the Q32.16 product to the row sum, and a
// row end returns the saturated sum, its row number and a clip flag on the
// result channel (o_res_valid, i_res_ready), then clears the sum.
// The vector RAM is read or written at most once per request, and the
// multiply and the saturating add each have a stage. A row end passes the
// RAM read stage, the multiply stage and the output register in turn.
// Reset clears the sum, the clip flag, the row counter and all valid bits;
// the vector RAM keeps whatever it holds and must be loaded before use.
// While a result waits, requests are still taken; only a second row end
// reaching the output stage while the first is unread stalls the pipeline,
// and o_ready then falls until the receiver takes the waiting result.
// ----------------------------------------------------------------------------
`include "csr_sparse_matrix_vector_multiply_assert.svh"

module csr_sparse_matrix_vector_multiply (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_op,
    input  logic [csmv_pkg::INDEX_W-1:0]         i_index,
    input  logic signed [csmv_pkg::VALUE_W-1:0]  i_value,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output logic signed [csmv_pkg::SUM_W-1:0]    o_row_sum,
    output logic [15:0]                          o_row_number,
    output logic                                 o_saturated
);

    localparam logic signed [csmv_pkg::SUM_W:0] SAT_MAX =
        {2'b00, {(csmv_pkg::SUM_W-1){1'b1}}};
    localparam logic signed [csmv_pkg::SUM_W:0] SAT_MIN =
        {2'b11, {(csmv_pkg::SUM_W-1){1'b0}}};

    logic                                w_adv;
    logic                                w_accept;
    logic                                w_in_range;
    logic                                w_ram_en;
    logic                                w_ram_we;
    logic [csmv_pkg::VALUE_W-1:0]        w_rdata;
    logic                                w_emit;

    logic                                r_s1_valid;
    csmv_pkg::t_op                       r_s1_op;
    logic                                r_s1_in_range;
    logic signed [csmv_pkg::VALUE_W-1:0] r_s1_value;

    logic                                r_s2_valid;
    csmv_pkg::t_op                       r_s2_op;
    logic signed [csmv_pkg::PROD_W-1:0]  r_s2_prod;

    logic signed [csmv_pkg::SUM_W-1:0]   r_sum;
    logic signed [csmv_pkg::SUM_W-1:0]   n_sum;
    logic                                r_clip;
    logic                                n_clip;
    logic [csmv_pkg::ROW_W-1:0]          r_row_cnt;

    logic                                r_out_valid;
    logic signed [csmv_pkg::SUM_W-1:0]   r_out_sum;
    logic [15:0]                         r_out_row;
    logic                                r_out_clip;

    logic signed [csmv_pkg::SUM_W-1:0]   w_term;
    logic signed [csmv_pkg::SUM_W:0]     w_wide;

    assign w_adv      = !(r_s2_valid && (r_s2_op == csmv_pkg::OP_ROW_END)
                          && r_out_valid && !i_res_ready);
    assign o_ready    = w_adv;
    assign w_accept   = i_valid && w_adv;
    assign w_in_range = (32'(i_index) < 32'(csmv_pkg::VECTOR_DEPTH));
    assign w_ram_we   = (i_op == csmv_pkg::OP_LOAD) && w_in_range;
    assign w_ram_en   = w_accept && w_in_range
                        && ((i_op == csmv_pkg::OP_LOAD) || (i_op == csmv_pkg::OP_NONZERO));
    assign w_emit     = w_adv && r_s2_valid && (r_s2_op == csmv_pkg::OP_ROW_END);

    csmv_ram #(
        .WIDTH(csmv_pkg::VALUE_W),
        .DEPTH(csmv_pkg::VECTOR_DEPTH)
    ) u_vec_ram (
        .i_clk  (i_clk),
        .i_en   (w_ram_en),
        .i_we   (w_ram_we),
        .i_addr (csmv_pkg::ADDR_W'(i_index)),
        .i_wdata(i_value),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_term = r_s2_prod[csmv_pkg::PROD_W-1:csmv_pkg::FRAC_W];
        w_wide = (csmv_pkg::SUM_W+1)'(r_sum) + (csmv_pkg::SUM_W+1)'(w_term);
        n_sum  = r_sum;
        n_clip = r_clip;
        if (r_s2_valid && (r_s2_op == csmv_pkg::OP_NONZERO)) begin
            if (w_wide > SAT_MAX) begin
                n_sum  = SAT_MAX[csmv_pkg::SUM_W-1:0];
                n_clip = 1'b1;
            end else if (w_wide < SAT_MIN) begin
                n_sum  = SAT_MIN[csmv_pkg::SUM_W-1:0];
                n_clip = 1'b1;
            end else begin
                n_sum  = w_wide[csmv_pkg::SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_sum       <= '0;
            r_clip      <= 1'b0;
            r_row_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s1_valid <= w_accept;
                r_s2_valid <= r_s1_valid;
                if (w_emit) begin
                    r_sum  <= '0;
                    r_clip <= 1'b0;
                    if (r_row_cnt == csmv_pkg::ROW_W'(csmv_pkg::MAX_ROWS - 1)) begin
                        r_row_cnt <= '0;
                    end else begin
                        r_row_cnt <= r_row_cnt + 1'b1;
                    end
                end else begin
                    r_sum  <= n_sum;
                    r_clip <= n_clip;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_op       <= i_op;
            r_s1_in_range <= w_in_range;
            r_s1_value    <= i_value;
            r_s2_op       <= r_s1_op;
            if (r_s1_in_range) begin
                r_s2_prod <= csmv_pkg::PROD_W'(r_s1_value)
                             * csmv_pkg::PROD_W'($signed(w_rdata));
            end else begin
                r_s2_prod <= '0;
            end
        end
        if (w_emit) begin
            r_out_sum  <= r_sum;
            r_out_row  <= 16'(r_row_cnt);
            r_out_clip <= r_clip;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_row_sum    = r_out_sum;
    assign o_row_number = r_out_row;
    assign o_saturated  = r_out_clip;

    `CSMV_ASSERT(a_emit_sets_valid, w_emit |=> r_out_valid, "row end did not raise result valid")
    `CSMV_ASSERT(a_emit_clears_sum, w_emit |=> (r_sum == '0) && !r_clip, "row sum not cleared")
    `CSMV_ASSERT(a_stall_cause, !w_adv |-> r_out_valid && !i_res_ready, "stall without full output")
    `CSMV_ASSERT(a_clip_sticky, r_clip && !w_emit |=> r_clip, "clip flag dropped inside a row")
    `CSMV_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !r_out_valid && !r_s1_valid, "reset left valid")

endmodule

FILE: rtl/csmv_ram.sv
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector multiply RAM
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module csmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
